@@ design/lfpd_pkg.sv @@
// Shared types and constants for the line-follow PID drive block.
// Holds the configuration register struct, register indexes and field widths.
// No dependencies.
package lfpd_pkg;

	// Field widths
	localparam int POS_W  = 14;
	localparam int ERR_W  = POS_W + 1;
	localparam int GAIN_W = 24;
	localparam int SPD_W  = 7;
	localparam int OUT_W  = 8;
	localparam int FRAC_W = 16;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;

	// Register indexes on the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_REFERENCE  = 3'd0,
		REG_GAIN_P     = 3'd1,
		REG_GAIN_I     = 3'd2,
		REG_GAIN_D     = 3'd3,
		REG_BASE_LEFT  = 3'd4,
		REG_BASE_RIGHT = 3'd5,
		REG_MAX_LEFT   = 3'd6,
		REG_MAX_RIGHT  = 3'd7
	} reg_idx_t;

	// Reset values
	localparam logic [POS_W-1:0]  RST_REFERENCE = 14'd3500;
	localparam logic [GAIN_W-1:0] RST_GAIN_P    = 24'd4522;
	localparam logic [GAIN_W-1:0] RST_GAIN_I    = 24'd131;
	localparam logic [GAIN_W-1:0] RST_GAIN_D    = 24'd131072;
	localparam logic [SPD_W-1:0]  RST_BASE      = 7'd18;
	localparam logic [SPD_W-1:0]  RST_MAX       = 7'd23;

	typedef struct packed {
		logic [POS_W-1:0]  reference;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [SPD_W-1:0]  base_left;
		logic [SPD_W-1:0]  base_right;
		logic [SPD_W-1:0]  max_left;
		logic [SPD_W-1:0]  max_right;
	} cfg_t;

endpackage

@@ design/line_follow_pid_drive.sv @@
// Line-follow PID drive: for each line position request, error = reference -
// position feeds a PID correction (Q8.16 gains, windowed error sum over
// WINDOW_TAPS samples, truncated toward zero) that is added to the left base
// speed and subtracted from the right, each clamped to -1 .. its maximum.
// A request is taken in any cycle in which the result register is empty or its
// result is being taken, so with out_ready high one request passes every cycle;
// its speeds are registered in the result register on acceptance. While a
// result waits for out_ready, in_ready stays low.
// Depends on lfpd_pkg, lfpd_cfg_regs, lfpd_err_hist, lfpd_drive_calc.
module line_follow_pid_drive import lfpd_pkg::*; #(
	parameter int WINDOW_TAPS = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] left_speed,
	output logic signed [OUT_W-1:0] right_speed
);

	localparam int HIST_DEPTH = (WINDOW_TAPS > 1) ? WINDOW_TAPS - 1 : 1;
	localparam int WIN_W      = ERR_W + $clog2(WINDOW_TAPS);

	cfg_t                    cfg;
	logic                    accept;
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] prev_err;
	logic signed [WIN_W-1:0] window;
	logic signed [ERR_W:0]   diff;
	logic signed [OUT_W-1:0] left_next, right_next;
	logic                    valid_s1;
	logic signed [OUT_W-1:0] left_s1, right_s1;

	lfpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Take a new request whenever the result register is free or draining
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	assign err = $signed({1'b0, cfg.reference}) - $signed({1'b0, position});

	lfpd_err_hist #(
		.WINDOW_TAPS (WINDOW_TAPS),
		.HIST_DEPTH  (HIST_DEPTH),
		.WIN_W       (WIN_W)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (accept),
		.err      (err),
		.prev_err (prev_err),
		.window   (window),
		.diff     (diff)
	);

	lfpd_drive_calc #(
		.WIN_W (WIN_W)
	) u_calc (
		.cfg         (cfg),
		.err         (err),
		.window      (window),
		.diff        (diff),
		.left_speed  (left_next),
		.right_speed (right_next)
	);

	// Result valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= left_next;
			right_s1 <= right_next;
		end
	end

	assign out_valid   = valid_s1;
	assign left_speed  = left_s1;
	assign right_speed = right_s1;

	// An accepted request always yields a pending result next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request produced no result");

	// The history holds the error of the last accepted request
	a_hist_tracks_err: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> prev_err == $past(err))
		else $error("error history did not take the accepted error");

	// Speeds never fall below -1
	a_speed_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!left_speed[OUT_W-1] || left_speed == -OUT_W'(1)) &&
			(!right_speed[OUT_W-1] || right_speed == -OUT_W'(1))))
		else $error("speed below lower clamp");

endmodule

@@ design/lfpd_cfg_regs.sv @@
// Configuration register file of the line-follow PID drive block.
// Depends on lfpd_pkg for the register struct, indexes and reset values.
module lfpd_cfg_regs import lfpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Write one register per enabled cycle, masked to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference  <= RST_REFERENCE;
			cfg_q.gain_p     <= RST_GAIN_P;
			cfg_q.gain_i     <= RST_GAIN_I;
			cfg_q.gain_d     <= RST_GAIN_D;
			cfg_q.base_left  <= RST_BASE;
			cfg_q.base_right <= RST_BASE;
			cfg_q.max_left   <= RST_MAX;
			cfg_q.max_right  <= RST_MAX;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_REFERENCE:  cfg_q.reference  <= cfg_data[POS_W-1:0];
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data[GAIN_W-1:0];
				REG_BASE_LEFT:  cfg_q.base_left  <= cfg_data[SPD_W-1:0];
				REG_BASE_RIGHT: cfg_q.base_right <= cfg_data[SPD_W-1:0];
				REG_MAX_LEFT:   cfg_q.max_left   <= cfg_data[SPD_W-1:0];
				REG_MAX_RIGHT:  cfg_q.max_right  <= cfg_data[SPD_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/lfpd_err_hist.sv @@
// Error history of the line-follow PID drive block: shift line of past errors,
// windowed error sum and error difference. Depends on lfpd_pkg for widths.
module lfpd_err_hist import lfpd_pkg::*; #(
	parameter int WINDOW_TAPS = 5,
	parameter int HIST_DEPTH  = 4,
	parameter int WIN_W       = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  logic signed [ERR_W-1:0] err,
	output logic signed [ERR_W-1:0] prev_err,
	output logic signed [WIN_W-1:0] window,
	output logic signed [ERR_W:0]   diff
);

	logic signed [ERR_W-1:0] hist_q [HIST_DEPTH];

	// Shift the current error in on each accepted request, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (shift) begin
			hist_q[0] <= err;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Sum the current error and the previous taps
	always_comb begin
		window = WIN_W'(err);
		for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
			window = window + WIN_W'(hist_q[i]);
		end
	end

	assign prev_err = hist_q[0];
	assign diff     = (ERR_W+1)'(err) - (ERR_W+1)'(hist_q[0]);

endmodule

@@ design/lfpd_drive_calc.sv @@
// Correction and speed clamp of the line-follow PID drive block: three gain
// products, sum, truncation toward zero, clamp. Depends on lfpd_pkg.
module lfpd_drive_calc import lfpd_pkg::*; #(
	parameter int WIN_W = 18
) (
	input  cfg_t                    cfg,
	input  logic signed [ERR_W-1:0] err,
	input  logic signed [WIN_W-1:0] window,
	input  logic signed [ERR_W:0]   diff,
	output logic signed [OUT_W-1:0] left_speed,
	output logic signed [OUT_W-1:0] right_speed
);

	localparam int TERM_W = (WIN_W > ERR_W + 1) ? WIN_W : ERR_W + 1;
	localparam int ACC_W  = GAIN_W + 1 + TERM_W + 2;
	localparam int CORR_W = ACC_W - FRAC_W;
	localparam int SUM_W  = CORR_W + 1;

	logic signed [GAIN_W:0]           gp_s, gi_s, gd_s;
	logic signed [GAIN_W+ERR_W:0]     prod_p;
	logic signed [GAIN_W+WIN_W:0]     prod_i;
	logic signed [GAIN_W+ERR_W+1:0]   prod_d;
	logic signed [ACC_W-1:0]          acc, bias, acc_rnd;
	logic signed [CORR_W-1:0]         corr;
	logic signed [SUM_W-1:0]          left_sum, right_sum;
	logic signed [SUM_W-1:0]          left_hi, right_hi;

	// Gains are unsigned; give them a zero sign bit
	assign gp_s = $signed({1'b0, cfg.gain_p});
	assign gi_s = $signed({1'b0, cfg.gain_i});
	assign gd_s = $signed({1'b0, cfg.gain_d});

	assign prod_p = gp_s * err;
	assign prod_i = gi_s * window;
	assign prod_d = gd_s * diff;

	assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

	// Drop the fraction, truncating toward zero
	assign bias    = acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0;
	assign acc_rnd = acc + bias;
	assign corr    = acc_rnd[ACC_W-1:FRAC_W];

	assign left_sum  = SUM_W'($signed({1'b0, cfg.base_left})) + SUM_W'(corr);
	assign right_sum = SUM_W'($signed({1'b0, cfg.base_right})) - SUM_W'(corr);
	assign left_hi   = SUM_W'($signed({1'b0, cfg.max_left}));
	assign right_hi  = SUM_W'($signed({1'b0, cfg.max_right}));

	// Clamp each side to -1 .. max
	always_comb begin
		priority if (left_sum > left_hi) begin
			left_speed = OUT_W'(left_hi);
		end else if (left_sum < -SUM_W'(1)) begin
			left_speed = -OUT_W'(1);
		end else begin
			left_speed = left_sum[OUT_W-1:0];
		end
	end

	always_comb begin
		priority if (right_sum > right_hi) begin
			right_speed = OUT_W'(right_hi);
		end else if (right_sum < -SUM_W'(1)) begin
			right_speed = -OUT_W'(1);
		end else begin
			right_speed = right_sum[OUT_W-1:0];
		end
	end

endmodule
